FILE: hw/rtl/sfp_pkg.sv
// Shared constants and controller-to-datapath signal types of the sensor frame parser.
package sfp_pkg;

	localparam int FRAME_LEN_DEF = 13;
	localparam int BYTE_W = 8;
	localparam int IDX_W = 4;

	localparam logic [BYTE_W-1:0] HDR_BYTE = 8'hAA;
	localparam logic [BYTE_W-1:0] TAIL_BYTE = 8'h55;

	typedef struct packed {
		logic take;
		logic rd;
		logic adv;
	} sfp_cmd_t;

	typedef struct packed {
		logic frame_good;
		logic last_rd;
	} sfp_sts_t;

endpackage

FILE: hw/rtl/sfp_ctrl.sv
// Controller state machine of the sensor frame parser: receive, payload read and word output.
module sfp_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	input  sfp_pkg::sfp_sts_t sts,
	output sfp_pkg::sfp_cmd_t cmd
);
	import sfp_pkg::*;

	localparam logic [1:0] ST_RX  = 2'd0;
	localparam logic [1:0] ST_RD  = 2'd1;
	localparam logic [1:0] ST_OUT = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign in_stall  = (state_q != ST_RX);
	assign out_valid = (state_q == ST_OUT);

	assign cmd.take = in_valid && (state_q == ST_RX);
	assign cmd.rd   = (state_q == ST_RD);
	assign cmd.adv  = (state_q == ST_OUT) && !out_stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_RX: begin
				if (cmd.take && sts.frame_good) begin
					state_d = ST_RD;
				end
			end
			ST_RD: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!out_stall) begin
					state_d = sts.last_rd ? ST_RX : ST_RD;
				end
			end
			default: begin
				state_d = ST_RX;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RX;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: hw/rtl/sfp_dp.sv
// Datapath of the sensor frame parser: frame position, checksum, payload store and readout.
module sfp_dp #(
	parameter int FRAME_LEN = sfp_pkg::FRAME_LEN_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  sfp_pkg::sfp_cmd_t          cmd,
	output sfp_pkg::sfp_sts_t          sts,
	input  logic [sfp_pkg::BYTE_W-1:0] rx_byte,
	output logic [sfp_pkg::BYTE_W-1:0] payload_byte,
	output logic [sfp_pkg::IDX_W-1:0]  payload_index,
	output logic                       last
);
	import sfp_pkg::*;

	localparam int PL = FRAME_LEN - 3;
	localparam int CW = $clog2(FRAME_LEN);
	localparam int AW = (PL > 1) ? $clog2(PL) : 1;
	localparam logic [CW-1:0] CSUM_POS = CW'(FRAME_LEN - 2);
	localparam logic [CW-1:0] TAIL_POS = CW'(FRAME_LEN - 1);
	localparam logic [CW-1:0] PL_POS = CW'(PL);
	localparam logic [AW-1:0] LAST_IDX = AW'(PL - 1);

	logic              in_frame_q;
	logic [CW-1:0]     cnt_q;
	logic [BYTE_W-1:0] sum_q;
	logic              csum_ok_q;
	logic [AW-1:0]     rd_idx_q;
	logic [BYTE_W-1:0] rdata_q;
	logic [BYTE_W-1:0] mem [PL];

	logic              hdr;
	logic              act;
	logic [CW-1:0]     pos;
	logic              is_pay;
	logic [AW-1:0]     wr_addr;
	logic [BYTE_W-1:0] sum_d;

	assign hdr     = (rx_byte == HDR_BYTE);
	assign act     = hdr || in_frame_q;
	assign pos     = hdr ? '0 : cnt_q;
	assign is_pay  = (pos != '0) && (pos <= PL_POS);
	assign wr_addr = AW'(pos - CW'(1));
	assign sum_d   = hdr ? '0 : (is_pay ? sum_q + rx_byte : sum_q);

	assign sts.frame_good = cmd.take && !hdr && in_frame_q && (pos == TAIL_POS)
		&& (rx_byte == TAIL_BYTE) && csum_ok_q;
	assign sts.last_rd = (rd_idx_q == LAST_IDX);

	assign payload_byte  = rdata_q;
	assign payload_index = IDX_W'(rd_idx_q);
	assign last          = sts.last_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			cnt_q      <= '0;
			sum_q      <= '0;
			csum_ok_q  <= 1'b0;
			rd_idx_q   <= '0;
		end else begin
			if (cmd.take && act) begin
				sum_q <= sum_d;
				if (pos == CSUM_POS) begin
					csum_ok_q <= (sum_q == rx_byte);
				end
				if (pos == TAIL_POS) begin
					in_frame_q <= 1'b0;
					cnt_q      <= '0;
				end else begin
					in_frame_q <= 1'b1;
					cnt_q      <= pos + CW'(1);
				end
			end
			if (cmd.adv) begin
				rd_idx_q <= sts.last_rd ? '0 : rd_idx_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take && act && is_pay) begin
			mem[wr_addr] <= rx_byte;
		end
		if (cmd.rd) begin
			rdata_q <= mem[rd_idx_q];
		end
	end

endmodule

FILE: hw/rtl/sensor_frame_parser_sum_check_unit.sv
// Top level of the sensor frame parser. Received bytes enter one word per cycle while the block
// is receiving; a 0xAA byte always opens a new frame of FRAME_LEN bytes (header, FRAME_LEN-3
// payload bytes, checksum, 0x55 tail). The checksum is compared as it arrives and the tail at the
// last byte, so a frame is judged in the cycle its tail is taken. A good frame is then read back
// from the payload store, which has a single registered read port: each word is read, then held
// at the output while out_stall is high, and input is stalled for the whole run; a bad frame is
// dropped without output and the block goes on receiving.
module sensor_frame_parser_sum_check_unit #(
	parameter int FRAME_LEN = sfp_pkg::FRAME_LEN_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [sfp_pkg::BYTE_W-1:0] rx_byte,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [sfp_pkg::BYTE_W-1:0] payload_byte,
	output logic [sfp_pkg::IDX_W-1:0]  payload_index,
	output logic                       last
);
	import sfp_pkg::*;

	sfp_cmd_t cmd;
	sfp_sts_t sts;

	sfp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	sfp_dp #(
		.FRAME_LEN (FRAME_LEN)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.rx_byte       (rx_byte),
		.payload_byte  (payload_byte),
		.payload_index (payload_index),
		.last          (last)
	);

endmodule

FILE: hw/rtl/sfp_checker.sv
// Port-level assertion checker for the sensor frame parser, with its bind to the top level.
module sfp_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [sfp_pkg::BYTE_W-1:0] payload_byte,
	input logic [sfp_pkg::IDX_W-1:0]  payload_index,
	input logic                       last
);
	import sfp_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(payload_byte)
			&& $stable(payload_index) && $stable(last))
		else $error("stalled output word changed");

	a_in_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken during payload run");

	a_run_next: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> !out_valid && in_stall ##1
			out_valid && (payload_index == IDX_W'($past(payload_index, 2) + 1'b1)))
		else $error("payload run broken or index out of order");

	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && last |=> !out_valid && !in_stall)
		else $error("block did not return to receiving after last word");

endmodule

bind sensor_frame_parser_sum_check_unit sfp_checker u_sfp_checker (.*);
